// ===== rtl/icsr_pkg.sv =====
//------------------------------------------------------------------------------
// icsr_pkg
// Shared types and constants for the incremental CSR index codec.
//------------------------------------------------------------------------------
`default_nettype none

package icsr_pkg;

    typedef enum logic [0:0] {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } icsr_mode_t;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COL_COUNT = 2'd1;

    // Column count after reset, truncated to the column width where used
    localparam logic [63:0] COL_COUNT_RESET = 64'd16777216;

    typedef struct packed {
        logic row_start;
        logic order_error;
    } icsr_flags_t;

endpackage

`default_nettype wire

// ===== rtl/icsr_core.sv =====
//------------------------------------------------------------------------------
// icsr_core
// Per-beat encode/decode logic with the row/column tracking state.
//------------------------------------------------------------------------------
`default_nettype none

module icsr_core
    import icsr_pkg::*;
#(
    parameter int INDEX_BITS = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire icsr_mode_t            mode,
    input  wire logic [INDEX_BITS:0]   col_count,
    input  wire logic [INDEX_BITS-1:0] row,
    input  wire logic [INDEX_BITS:0]   col_or_delta,
    output logic [INDEX_BITS:0]        code,
    output logic [INDEX_BITS-1:0]      skip,
    output icsr_flags_t                flags
);

    localparam int COL_W = INDEX_BITS + 1;

    logic [INDEX_BITS-1:0] prev_row_reg;
    logic [COL_W-1:0]      last_col_reg;
    logic                  seen_reg;
    logic [COL_W-1:0]      acc_reg;

    // encode
    logic                  new_row;
    logic                  enc_err;
    logic [COL_W-1:0]      enc_code;
    logic [INDEX_BITS-1:0] enc_skip;

    // decode: wrap and overflow checks run side by side
    logic [COL_W:0]        sum;
    logic [COL_W:0]        twice_cc;
    logic [COL_W:0]        sum_wrapped;
    logic                  wrapped;
    logic                  dec_err;
    logic [COL_W-1:0]      dec_code;

    logic                  err;

    always_comb
    begin
        new_row = !seen_reg || (row != prev_row_reg);
        enc_err = (col_or_delta >= col_count)
               || (seen_reg && (row < prev_row_reg))
               || (seen_reg && (row == prev_row_reg) && (col_or_delta <= last_col_reg));
        if (!seen_reg)
        begin
            enc_code = col_or_delta;
            enc_skip = row;
        end
        else if (new_row)
        begin
            enc_code = col_count - last_col_reg + col_or_delta;
            enc_skip = row - prev_row_reg;
        end
        else
        begin
            enc_code = col_or_delta - last_col_reg;
            enc_skip = '0;
        end
    end

    always_comb
    begin
        sum         = {1'b0, acc_reg} + {1'b0, col_or_delta};
        twice_cc    = {col_count, 1'b0};
        sum_wrapped = sum - {1'b0, col_count};
        wrapped     = sum >= {1'b0, col_count};
        dec_err     = wrapped ? (sum >= twice_cc) : 1'b0;
        dec_code    = wrapped ? sum_wrapped[COL_W-1:0] : sum[COL_W-1:0];
    end

    always_comb
    begin
        unique case (mode)
            MODE_ENCODE:
            begin
                err             = enc_err;
                code            = enc_code;
                skip            = enc_skip;
                flags.row_start = new_row;
            end
            MODE_DECODE:
            begin
                err             = dec_err;
                code            = dec_code;
                skip            = '0;
                flags.row_start = wrapped;
            end
            default:
            begin
                err             = 1'b1;
                code            = '0;
                skip            = '0;
                flags.row_start = 1'b0;
            end
        endcase
        flags.order_error = err;
        // a failed check blanks the result fields
        if (err)
        begin
            code            = '0;
            skip            = '0;
            flags.row_start = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_row_reg <= '0;
            last_col_reg <= COL_COUNT_RESET[COL_W-1:0];
            seen_reg     <= 1'b0;
            acc_reg      <= '0;
        end
        else if (fire && !err)
        begin
            if (mode == MODE_ENCODE)
            begin
                prev_row_reg <= row;
                last_col_reg <= col_or_delta;
                seen_reg     <= 1'b1;
            end
            else
            begin
                acc_reg <= dec_code;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/incremental_csr_index_codec.sv =====
//------------------------------------------------------------------------------
// incremental_csr_index_codec
// Converts a row-major stream of nonzeros between CSR column indices and
// incremental deltas.
//------------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries row_index, col_or_delta and value.
//   Output channel (out_valid/out_stall) returns code_out, row_start, row_skip,
//   value_out and order_error, one result beat per input beat, in order.
//   cfg_write/cfg_index/cfg_data write mode (index 0) and col_count (index 1);
//   other indexes are ignored. Write only while the block is empty.
// Path: input register, then output register. Throughput: one beat per cycle
//   while out_stall is low; the encode/decode state is updated in the same
//   cycle the result is computed, so back-to-back beats see it at once.
// Stall: when out_stall holds the output register, one more beat is taken into
//   the input register; after that in_stall rises until the output drains.
// Reset: both pipeline registers empty, encode mode, col_count 16777216, row
//   tracking cleared, last column 16777216, decode accumulator zero.
//------------------------------------------------------------------------------
`default_nettype none

module incremental_csr_index_codec
    import icsr_pkg::*;
#(
    parameter int INDEX_BITS = 24,
    parameter int VALUE_BITS = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [INDEX_BITS:0]       cfg_data,

    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [INDEX_BITS-1:0]     row_index,
    input  wire logic [INDEX_BITS:0]       col_or_delta,
    input  wire logic [VALUE_BITS-1:0]     value,

    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [INDEX_BITS:0]            code_out,
    output logic                           row_start,
    output logic [INDEX_BITS-1:0]          row_skip,
    output logic [VALUE_BITS-1:0]          value_out,
    output logic                           order_error
);

    localparam int COL_W = INDEX_BITS + 1;

    icsr_mode_t            mode_reg;
    logic [COL_W-1:0]      col_count_reg;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [INDEX_BITS-1:0] s1_row_reg;
    logic [COL_W-1:0]      s1_cd_reg;
    logic [VALUE_BITS-1:0] s1_value_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COL_W-1:0]      code_reg;
    logic [INDEX_BITS-1:0] skip_reg;
    icsr_flags_t           flags_reg;
    logic [VALUE_BITS-1:0] value_out_reg;

    logic                  accept;
    logic                  advance;
    logic [COL_W-1:0]      core_code;
    logic [INDEX_BITS-1:0] core_skip;
    icsr_flags_t           core_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ENCODE;
            col_count_reg <= COL_COUNT_RESET[COL_W-1:0];
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MODE:      mode_reg      <= icsr_mode_t'(cfg_data[0]);
                CFG_COL_COUNT: col_count_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // pipeline handshake
    always_comb
    begin
        advance        = s1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall       = s1_valid_reg && !advance;
        accept         = in_valid && !in_stall;
        s1_valid_next  = accept || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg   <= row_index;
            s1_cd_reg    <= col_or_delta;
            s1_value_reg <= value;
        end
        if (advance)
        begin
            code_reg      <= core_code;
            skip_reg      <= core_skip;
            flags_reg     <= core_flags;
            value_out_reg <= s1_value_reg;
        end
    end

    icsr_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .mode         (mode_reg),
        .col_count    (col_count_reg),
        .row          (s1_row_reg),
        .col_or_delta (s1_cd_reg),
        .code         (core_code),
        .skip         (core_skip),
        .flags        (core_flags)
    );

    assign out_valid   = out_valid_reg;
    assign code_out    = code_reg;
    assign row_start   = flags_reg.row_start;
    assign row_skip    = skip_reg;
    assign value_out   = value_out_reg;
    assign order_error = flags_reg.order_error;

    // a failed check never carries result fields
    a_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && flags_reg.order_error)
            |-> (code_reg == '0 && !flags_reg.row_start && skip_reg == '0))
        else $error("error beat carries result fields");

    // the input side only stalls with a beat held in the input register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    // a held beat moves to the output whenever the output can take it
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !(out_valid_reg && out_stall)) |=> out_valid_reg)
        else $error("beat lost between stages");

    // decode never reports a row skip
    a_dec_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_reg == MODE_DECODE) |=> (skip_reg == '0))
        else $error("row skip in decode mode");

endmodule

`default_nettype wire
